@@ design/hiqp_pkg.sv @@
// ----------------------------------------------------------------------------
// hiqp_pkg
// Shared types and constants for the quadratic-probe hash insert core.
// ----------------------------------------------------------------------------
package hiqp_pkg;

  localparam int KEY_W          = 31;
  localparam int SEL_W          = 4;
  localparam int STATUS_W       = 2;
  localparam int DEF_TABLE_SIZE = 16;
  localparam int DEF_MAX_PROBES = 16;
  localparam int Q_DEPTH        = 2;
  // key bits folded into the home-slot remainder per cycle
  localparam int MOD_STEP       = 4;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_SLOT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE,
    BK_RDATA
  } bk_state_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [SEL_W-1:0] sel;
  } item_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [SEL_W-1:0] slot_index;
    logic             used;
    logic [KEY_W-1:0] key;
  } result_t;

endpackage

@@ design/hiqp_front.sv @@
// ----------------------------------------------------------------------------
// hiqp_front
// Takes a beat, holds it and works out the home slot (key mod table size;
// MOD_STEP key bits per cycle for a non-power-of-two insert), then queues it.
// ----------------------------------------------------------------------------
module hiqp_front import hiqp_pkg::*; #(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE,
  parameter int IDX_W      = $clog2(DEF_TABLE_SIZE)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  item_t            in_item,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output item_t            push_item,
  output logic [IDX_W-1:0] push_home
);

  localparam bit POW2  = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
  localparam int NSTEP = (KEY_W + MOD_STEP - 1) / MOD_STEP;
  localparam int PAD_W = NSTEP * MOD_STEP;
  localparam int CNT_W = $clog2(NSTEP + 1);
  localparam int REM_W = IDX_W + 1;
  localparam logic [REM_W-1:0] MODULUS = REM_W'(TABLE_SIZE);

  logic             busy_r;
  logic             calc_r;
  item_t            item_r;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;
  logic [PAD_W-1:0] shf_r;
  logic [CNT_W-1:0] cnt_r;

  // restoring remainder over the next group of key bits, msb first
  always_comb begin
    rem_nxt = rem_r;
    for (int i = 0; i < MOD_STEP; i++) begin
      rem_nxt = {rem_nxt[REM_W-2:0], shf_r[PAD_W-1-i]};
      if (rem_nxt >= MODULUS) begin
        rem_nxt = rem_nxt - MODULUS;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      calc_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
      calc_r <= (in_item.op == OP_INSERT) && !POW2;
    end else if (calc_r) begin
      if (cnt_r == CNT_W'(1)) begin
        calc_r <= 1'b0;
      end
    end else if (push) begin
      busy_r <= 1'b0;
    end
  end

  // held beat and remainder
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
      cnt_r  <= CNT_W'(NSTEP);
      shf_r  <= PAD_W'(in_item.key);
      if (POW2) begin
        rem_r <= {1'b0, in_item.key[IDX_W-1:0]};
      end else begin
        rem_r <= '0;
      end
    end else if (calc_r) begin
      rem_r <= rem_nxt;
      shf_r <= shf_r << MOD_STEP;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign busy      = busy_r;
  assign push      = busy_r && !calc_r && !q_full;
  assign push_item = item_r;
  assign push_home = rem_r[IDX_W-1:0];

endmodule

@@ design/hiqp_queue.sv @@
// ----------------------------------------------------------------------------
// hiqp_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module hiqp_queue import hiqp_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = Q_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] ent_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = ent_r[rd_ptr_r];
  assign full     = cnt_r == CNT_W'(DEPTH);
  assign empty    = cnt_r == '0;

endmodule

@@ design/hiqp_back.sv @@
// ----------------------------------------------------------------------------
// hiqp_back
// Slot memory and probe engine: clears the table after reset, serves slot
// reads and walks the quadratic probe sequence one slot per cycle.
// ----------------------------------------------------------------------------
module hiqp_back import hiqp_pkg::*; #(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE,
  parameter int MAX_PROBES = DEF_MAX_PROBES,
  parameter int IDX_W      = $clog2(DEF_TABLE_SIZE)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  item_t            q_item,
  input  logic [IDX_W-1:0] q_home,
  output logic             pop,
  output logic             clearing,
  output result_t          result
);

  localparam int REM_W = IDX_W + 1;
  localparam int PRB_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int ENT_W = KEY_W + 1;
  localparam int ODD_INIT = 3 % TABLE_SIZE;
  localparam int TWO_MOD  = 2 % TABLE_SIZE;
  localparam logic [REM_W-1:0] MODULUS   = REM_W'(TABLE_SIZE);
  localparam logic [PRB_W-1:0] LAST_PRB  = PRB_W'(MAX_PROBES - 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SIZE - 1);

  bk_state_t        state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] nxt_r, nxt_nxt;
  logic [IDX_W-1:0] odd_r, odd_nxt;
  logic [PRB_W-1:0] j_r, j_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [SEL_W-1:0] sel_r, sel_nxt;
  result_t          result_r, result_nxt;

  logic [ENT_W-1:0] slot_mem_r [TABLE_SIZE];
  logic [ENT_W-1:0] rd_data_r;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [ENT_W-1:0] wr_data;

  logic                   rd_used;
  logic [KEY_W-1:0]       rd_key;
  logic                   tbl_full;
  logic [IDX_W+SEL_W-1:0] sel_ext;
  logic                   sel_ok;

  // (a + b) mod table size for a, b already below it
  function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [REM_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MODULUS) begin
      s = s - MODULUS;
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [SEL_W-1:0] to_sel(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SEL_W-1:0] w;
    w = {{SEL_W{1'b0}}, idx};
    return w[SEL_W-1:0];
  endfunction

  assign rd_used  = rd_data_r[ENT_W-1];
  assign rd_key   = rd_data_r[KEY_W-1:0];
  assign tbl_full = cnt_r == CNT_W'(TABLE_SIZE);
  assign sel_ext  = {{IDX_W{1'b0}}, q_item.sel};
  assign sel_ok   = sel_ext < (IDX_W + SEL_W)'(TABLE_SIZE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR: begin
        if (clr_r == LAST_SLOT) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_item.op == OP_READ) begin
            if (sel_ok) begin
              state_nxt = BK_RDATA;
            end
          end else if (!tbl_full) begin
            state_nxt = BK_PROBE;
          end
        end
      end
      BK_PROBE: begin
        if (!rd_used || j_r == LAST_PRB) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_RDATA: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // outputs, memory controls and datapath updates
  always_comb begin
    pop        = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = cur_r;
    wr_en      = 1'b0;
    wr_addr    = cur_r;
    wr_data    = {1'b1, key_r};
    clr_nxt    = clr_r;
    cnt_nxt    = cnt_r;
    cur_nxt    = cur_r;
    nxt_nxt    = nxt_r;
    odd_nxt    = odd_r;
    j_nxt      = j_r;
    key_nxt    = key_r;
    sel_nxt    = sel_r;
    result_nxt = '0;
    unique case (state_r)
      BK_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + IDX_W'(1);
      end
      BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (q_item.op == OP_READ) begin
            sel_nxt = q_item.sel;
            if (sel_ok) begin
              rd_en   = 1'b1;
              rd_addr = sel_ext[IDX_W-1:0];
            end else begin
              // slot beyond the table reads as empty
              result_nxt.valid      = 1'b1;
              result_nxt.status     = ST_DONE;
              result_nxt.slot_index = q_item.sel;
            end
          end else if (tbl_full) begin
            result_nxt.valid  = 1'b1;
            result_nxt.status = ST_FULL;
          end else begin
            rd_en   = 1'b1;
            rd_addr = q_home;
            cur_nxt = q_home;
            nxt_nxt = mod_add(q_home, IDX_W'(1));
            odd_nxt = IDX_W'(ODD_INIT);
            j_nxt   = '0;
            key_nxt = q_item.key;
          end
        end
      end
      BK_PROBE: begin
        if (!rd_used) begin
          wr_en                 = 1'b1;
          wr_addr               = cur_r;
          wr_data               = {1'b1, key_r};
          cnt_nxt               = cnt_r + CNT_W'(1);
          result_nxt.valid      = 1'b1;
          result_nxt.status     = ST_DONE;
          result_nxt.slot_index = to_sel(cur_r);
          result_nxt.used       = 1'b1;
          result_nxt.key        = key_r;
        end else if (j_r == LAST_PRB) begin
          result_nxt.valid  = 1'b1;
          result_nxt.status = ST_NO_SLOT;
        end else begin
          // next square: step grows by two each probe
          rd_en   = 1'b1;
          rd_addr = nxt_r;
          cur_nxt = nxt_r;
          nxt_nxt = mod_add(nxt_r, odd_r);
          odd_nxt = mod_add(odd_r, IDX_W'(TWO_MOD));
          j_nxt   = j_r + PRB_W'(1);
        end
      end
      BK_RDATA: begin
        result_nxt.valid      = 1'b1;
        result_nxt.status     = ST_DONE;
        result_nxt.slot_index = sel_r;
        result_nxt.used       = rd_used;
        result_nxt.key        = rd_used ? rd_key : '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_CLEAR;
      clr_r    <= '0;
      cnt_r    <= '0;
      result_r <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      cnt_r    <= cnt_nxt;
      result_r <= result_nxt;
    end
  end

  // probe datapath
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    nxt_r <= nxt_nxt;
    odd_r <= odd_nxt;
    j_r   <= j_nxt;
    key_r <= key_nxt;
    sel_r <= sel_nxt;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem_r[rd_addr];
    end
  end

  assign clearing = state_r == BK_CLEAR;
  assign result   = result_r;

endmodule

@@ design/hash_insert_quadratic_probe_core.sv @@
// ----------------------------------------------------------------------------
// hash_insert_quadratic_probe_core
// Open-addressing hash table with quadratic probing: inserts keys and reads
// back single slots.
// ----------------------------------------------------------------------------
//  channel  ports                                     handshake
//  input    in_operation, in_key, in_slot_select      start high, busy low
//  result   out_status, out_slot_index, out_slot_used, out_strobe, one cycle
//           out_slot_key
//
//  After reset the slot memory is cleared, one slot a cycle, and busy stays
//  high until the last slot is cleared.
//  Front: a read, or an insert when TABLE_SIZE is a power of two, is held
//  and pushed when the queue has room; others first run the 4-bit-per-cycle
//  modulo. Back: a beat is dequeued in BK_IDLE and probes the slot memory's
//  registered read port in BK_PROBE; the result is registered. A 2-entry
//  queue lets the front take the next beat while the back probes.
//  Results cannot be held off; busy reflects the front and the table clear.
// ----------------------------------------------------------------------------
module hash_insert_quadratic_probe_core import hiqp_pkg::*; #(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE,
  parameter int MAX_PROBES = DEF_MAX_PROBES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_operation,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [SEL_W-1:0]    in_slot_select,
  output logic                out_strobe,
  output logic [STATUS_W-1:0] out_status,
  output logic [SEL_W-1:0]    out_slot_index,
  output logic                out_slot_used,
  output logic [KEY_W-1:0]    out_slot_key
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int DATA_W = $bits(item_t) + IDX_W;

  item_t             in_item;
  logic              accept;
  logic              front_busy;
  logic              clearing;
  logic              push;
  item_t             push_item;
  logic [IDX_W-1:0]  push_home;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  logic [DATA_W-1:0] q_data;
  item_t             q_item;
  logic [IDX_W-1:0]  q_home;
  result_t           result;

  // input beat
  assign in_item.op  = op_t'(in_operation);
  assign in_item.key = in_key;
  assign in_item.sel = in_slot_select;
  assign busy        = front_busy || clearing;
  assign accept      = start && !busy;

  hiqp_front #(
    .TABLE_SIZE (TABLE_SIZE),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .q_full    (q_full),
    .busy      (front_busy),
    .push      (push),
    .push_item (push_item),
    .push_home (push_home)
  );

  hiqp_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_item, push_home}),
    .pop       (pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {q_item, q_home} = q_data;

  hiqp_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .MAX_PROBES (MAX_PROBES),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_home   (q_home),
    .pop      (pop),
    .clearing (clearing),
    .result   (result)
  );

  // result beat
  assign out_strobe     = result.valid;
  assign out_status     = result.status;
  assign out_slot_index = result.slot_index;
  assign out_slot_used  = result.used;
  assign out_slot_key   = result.key;

endmodule

@@ design/hiqp_checker.sv @@
// ----------------------------------------------------------------------------
// hiqp_checker
// Port-level checks for the hash insert core, bound to the top level.
// ----------------------------------------------------------------------------
module hiqp_checker import hiqp_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                in_operation,
  input logic [KEY_W-1:0]    in_key,
  input logic [SEL_W-1:0]    in_slot_select,
  input logic                out_strobe,
  input logic [STATUS_W-1:0] out_status,
  input logic [SEL_W-1:0]    out_slot_index,
  input logic                out_slot_used,
  input logic [KEY_W-1:0]    out_slot_key
);

  // table is swept clear after reset, so no beat is taken right away
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low right after reset");

  // an accepted beat keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low right after accept");

  // failed inserts carry an all-zero slot
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == ST_FULL || out_status == ST_NO_SLOT) |->
      out_slot_index == '0 && !out_slot_used && out_slot_key == '0)
    else $error("failed insert with nonzero slot fields");

  // an empty slot shows a zero key
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_slot_used |-> out_slot_key == '0)
    else $error("unused slot with nonzero key");

  // no undefined status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |->
      out_status == ST_DONE || out_status == ST_FULL || out_status == ST_NO_SLOT)
    else $error("undefined status code");

endmodule

bind hash_insert_quadratic_probe_core hiqp_checker u_hiqp_checker (.*);
